// File: src/stereo_biquad_eq_cascade_unit_macros.svh
// ----------------------------------------------------------------------------
// stereo biquad equalizer assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef STEREO_BIQUAD_EQ_CASCADE_UNIT_MACROS_SVH
`define STEREO_BIQUAD_EQ_CASCADE_UNIT_MACROS_SVH

// same-cycle implication
`define SBQ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sbq assertion failed");

// next-cycle implication
`define SBQ_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sbq assertion failed");

`endif

// File: src/sbq_pkg.sv
// ----------------------------------------------------------------------------
// sbq_pkg
// widths, item types and rounding helpers of the stereo biquad equalizer
// ----------------------------------------------------------------------------
`default_nettype none
package sbq_pkg;
	localparam int SECTIONS    = 6;
	localparam int SAMPLE_BITS = 24;
	localparam int COEF_BITS   = 28;
	localparam int COEF_FRAC   = 22;
	localparam int NCOEF       = 5;
	localparam int HIST_BITS   = 32;
	localparam int GAIN_BITS   = 25;
	localparam int GAIN_FRAC   = 22;

	localparam int PROD_BITS   = COEF_BITS + HIST_BITS;
	localparam int ACC_BITS    = PROD_BITS + 4;
	localparam int GP_BITS     = HIST_BITS + GAIN_BITS + 2;
	localparam int COEF_DEPTH  = SECTIONS * NCOEF;
	localparam int CADDR_BITS  = $clog2(COEF_DEPTH);
	localparam int SEC_BITS    = $clog2(SECTIONS);
	localparam int SECW        = $clog2(SECTIONS + 1);
	localparam int HIST_DEPTH  = SECTIONS * 8;
	localparam int HADDR_BITS  = SEC_BITS + 3;
	localparam int QDEPTH      = 2;

	localparam logic signed [ACC_BITS-1:0] ACC_HALF = ACC_BITS'(1) << (COEF_FRAC - 1);
	localparam logic signed [ACC_BITS-1:0] HIST_MAX = ACC_BITS'((64'd1 << (HIST_BITS-1)) - 1);
	localparam logic signed [ACC_BITS-1:0] HIST_MIN = -HIST_MAX - ACC_BITS'(1);
	localparam logic signed [GP_BITS-1:0] GP_HALF = GP_BITS'(1) << (GAIN_FRAC - 1);
	localparam logic signed [GP_BITS-1:0] OUT_MAX = GP_BITS'((64'd1 << (SAMPLE_BITS-1)) - 1);
	localparam logic signed [GP_BITS-1:0] OUT_MIN = -OUT_MAX - GP_BITS'(1);

	typedef enum logic [1:0] {
		OP_PROC  = 2'd0,
		OP_WCOEF = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [1:0] CFG_ENABLE = 2'd0;
	localparam logic [1:0] CFG_GAIN   = 2'd1;

	typedef struct packed {
		op_t                           op;
		logic signed [SAMPLE_BITS-1:0] left;
		logic signed [SAMPLE_BITS-1:0] right;
		logic [CADDR_BITS-1:0]         caddr;
		logic signed [COEF_BITS-1:0]   cval;
	} item_t;

	typedef struct packed {
		logic valid;
		logic pop;
	} qctl_t;

	function automatic logic signed [HIST_BITS-1:0] round_sat_hist(
		input logic signed [ACC_BITS-1:0] a);
		logic signed [ACC_BITS-1:0] t;
		t = (a + ACC_HALF) >>> COEF_FRAC;
		if (t > HIST_MAX) return HIST_MAX[HIST_BITS-1:0];
		if (t < HIST_MIN) return HIST_MIN[HIST_BITS-1:0];
		return t[HIST_BITS-1:0];
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] round_sat_out(
		input logic signed [GP_BITS-1:0] a);
		logic signed [GP_BITS-1:0] t;
		t = (a + GP_HALF) >>> GAIN_FRAC;
		if (t > OUT_MAX) return OUT_MAX[SAMPLE_BITS-1:0];
		if (t < OUT_MIN) return OUT_MIN[SAMPLE_BITS-1:0];
		return t[SAMPLE_BITS-1:0];
	endfunction
endpackage
`default_nettype wire

// File: src/sbq_front.sv
// ----------------------------------------------------------------------------
// sbq_front
// accepts input transactions, drops those without effect, queues the rest
// ----------------------------------------------------------------------------
`default_nettype none
module sbq_front import sbq_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    operation,
	input  wire logic signed [SAMPLE_BITS-1:0] left_in,
	input  wire logic signed [SAMPLE_BITS-1:0] right_in,
	input  wire logic [2:0]                    coef_section,
	input  wire logic [2:0]                    coef_index,
	input  wire logic signed [COEF_BITS-1:0]   coef_value,
	output item_t                              q_item,
	output logic                               q_valid,
	input  wire logic                          q_pop
);
	localparam int QPTR = $clog2(QDEPTH);
	localparam int QCNT = $clog2(QDEPTH + 1);

	item_t            queue_q [QDEPTH];
	logic [QPTR-1:0]  wp_q, rp_q;
	logic [QCNT-1:0]  cnt_q;
	logic             keep, push, addr_ok;
	item_t            item;

	assign addr_ok = (int'(coef_section) < SECTIONS) && (int'(coef_index) < NCOEF);

	always_comb begin
		item.op    = op_t'(operation);
		item.left  = left_in;
		item.right = right_in;
		item.caddr = CADDR_BITS'(int'(coef_section) * NCOEF + int'(coef_index));
		item.cval  = coef_value;
		unique case (op_t'(operation))
			OP_PROC:  keep = 1'b1;
			OP_WCOEF: keep = addr_ok;
			OP_CLEAR: keep = 1'b1;
			default:  keep = 1'b0;
		endcase
	end

	assign in_stall = (cnt_q == QCNT'(QDEPTH));
	assign push     = in_valid && !in_stall && keep;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = queue_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) queue_q[wp_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (int'(wp_q) == QDEPTH-1) ? '0 : wp_q + 1'b1;
			if (q_pop) rp_q <= (int'(rp_q) == QDEPTH-1) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + QCNT'(push) - QCNT'(q_pop);
		end
	end
endmodule
`default_nettype wire

// File: src/sbq_back.sv
// ----------------------------------------------------------------------------
// sbq_back
// sequencer running the biquad sections on a shared multiply-accumulate unit
// ----------------------------------------------------------------------------
`default_nettype none
`include "stereo_biquad_eq_cascade_unit_macros.svh"
module sbq_back import sbq_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire item_t                         q_item,
	input  wire qctl_t                         qin,
	output logic                               q_pop,
	input  wire logic [SECTIONS-1:0]           section_enable,
	input  wire logic [GAIN_BITS-1:0]          output_gain,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0]      left_out,
	output logic signed [SAMPLE_BITS-1:0]      right_out
);
	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_SEC  = 9'b000000010,
		ST_RD   = 9'b000000100,
		ST_MUL  = 9'b000001000,
		ST_ACC  = 9'b000010000,
		ST_RND  = 9'b000100000,
		ST_WR   = 9'b001000000,
		ST_GAIN = 9'b010000000,
		ST_GSAT = 9'b100000000
	} state_t;

	state_t                        st_q;
	logic                          ch_q;
	logic [SECW-1:0]               sec_q;
	logic [2:0]                    term_q;
	logic [1:0]                    wr_q;
	logic signed [HIST_BITS-1:0]   x_q, y_q, h0_q, h2_q;
	logic signed [SAMPLE_BITS-1:0] right_q, left_q;
	logic signed [PROD_BITS-1:0]   prod_q;
	logic signed [ACC_BITS-1:0]    acc_q;
	logic signed [GP_BITS-1:0]     gp_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] left_out_q, right_out_q;

	logic signed [COEF_BITS-1:0]   coef_mem [COEF_DEPTH];
	logic [COEF_DEPTH-1:0]         cvld_q;
	logic signed [COEF_BITS-1:0]   coef_rd_q;
	logic signed [HIST_BITS-1:0]   hist_mem [HIST_DEPTH];
	logic [HIST_DEPTH-1:0]         hvld_q;
	logic signed [HIST_BITS-1:0]   hist_rd_q;

	logic [SEC_BITS-1:0]           sec_l;
	logic [CADDR_BITS-1:0]         caddr_rd;
	logic [HADDR_BITS-1:0]         haddr_rd, haddr_wr;
	logic [1:0]                    hk_rd, hk_wr;
	logic signed [HIST_BITS-1:0]   hwdata, opnd;
	logic                          coef_we, hist_we, hist_clr;
	logic                          out_load;
	logic signed [SAMPLE_BITS-1:0] res;

	assign sec_l    = sec_q[SEC_BITS-1:0];
	assign caddr_rd = CADDR_BITS'(int'(sec_l) * NCOEF + int'(term_q));
	assign hk_rd    = 2'(term_q - 3'd1);
	assign haddr_rd = {sec_l, ch_q, hk_rd};
	assign haddr_wr = {sec_l, ch_q, hk_wr};
	assign q_pop    = (st_q == ST_IDLE) && qin.valid;
	assign coef_we  = q_pop && (q_item.op == OP_WCOEF);
	assign hist_clr = q_pop && (q_item.op == OP_CLEAR);
	assign hist_we  = (st_q == ST_WR);
	assign opnd     = (term_q == 3'd0) ? x_q : hist_rd_q;
	assign res      = round_sat_out(gp_q);
	assign out_load = (st_q == ST_GSAT) && ch_q && (!out_valid_q || !out_stall);

	always_comb begin
		unique case (wr_q)
			2'd0: begin hk_wr = 2'd1; hwdata = h0_q; end
			2'd1: begin hk_wr = 2'd0; hwdata = x_q;  end
			2'd2: begin hk_wr = 2'd3; hwdata = h2_q; end
			default: begin hk_wr = 2'd2; hwdata = y_q; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (coef_we) coef_mem[q_item.caddr] <= q_item.cval;
		coef_rd_q <= cvld_q[caddr_rd] ? coef_mem[caddr_rd] : '0;
		if (hist_we) hist_mem[haddr_wr] <= hwdata;
		hist_rd_q <= hvld_q[haddr_rd] ? hist_mem[haddr_rd] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvld_q <= '0;
			hvld_q <= '0;
		end else begin
			if (coef_we) cvld_q[q_item.caddr] <= 1'b1;
			if (hist_clr) hvld_q <= '0;
			else if (hist_we) hvld_q[haddr_wr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			ch_q        <= 1'b0;
			sec_q       <= '0;
			term_q      <= '0;
			wr_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !out_load) out_valid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (q_pop && q_item.op == OP_PROC) begin
						x_q     <= HIST_BITS'(q_item.left);
						right_q <= q_item.right;
						ch_q    <= 1'b0;
						sec_q   <= '0;
						st_q    <= ST_SEC;
					end
				end
				ST_SEC: begin
					if (int'(sec_q) == SECTIONS) begin
						st_q <= ST_GAIN;
					end else if (section_enable[sec_l]) begin
						term_q <= '0;
						acc_q  <= '0;
						st_q   <= ST_RD;
					end else begin
						sec_q <= sec_q + 1'b1;
					end
				end
				ST_RD: st_q <= ST_MUL;
				ST_MUL: begin
					prod_q <= coef_rd_q * opnd;
					if (term_q == 3'd1) h0_q <= hist_rd_q;
					if (term_q == 3'd3) h2_q <= hist_rd_q;
					st_q <= ST_ACC;
				end
				ST_ACC: begin
					if (term_q < 3'd3) acc_q <= acc_q + ACC_BITS'(prod_q);
					else acc_q <= acc_q - ACC_BITS'(prod_q);
					term_q <= term_q + 3'd1;
					st_q   <= (int'(term_q) == NCOEF-1) ? ST_RND : ST_RD;
				end
				ST_RND: begin
					y_q  <= round_sat_hist(acc_q);
					wr_q <= '0;
					st_q <= ST_WR;
				end
				ST_WR: begin
					wr_q <= wr_q + 2'd1;
					if (wr_q == 2'd3) begin
						x_q   <= y_q;
						sec_q <= sec_q + 1'b1;
						st_q  <= ST_SEC;
					end
				end
				ST_GAIN: begin
					gp_q <= x_q * $signed({1'b0, output_gain});
					st_q <= ST_GSAT;
				end
				ST_GSAT: begin
					if (!ch_q) begin
						left_q <= res;
						ch_q   <= 1'b1;
						x_q    <= HIST_BITS'(right_q);
						sec_q  <= '0;
						st_q   <= ST_SEC;
					end else if (out_load) begin
						out_valid_q <= 1'b1;
						left_out_q  <= left_q;
						right_out_q <= res;
						st_q        <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_out_q;
	assign right_out = right_out_q;

	`SBQ_ASSERT_IMP(a_pop_needs_item, q_pop, qin.valid)
	`SBQ_ASSERT_NXT(a_mul_follows_rd, st_q == ST_RD, st_q == ST_MUL)
	`SBQ_ASSERT_IMP(a_sec_in_range, st_q == ST_RD, int'(sec_q) < SECTIONS)
	`SBQ_ASSERT_IMP(a_no_pop_busy, st_q != ST_IDLE, !q_pop)
endmodule
`default_nettype wire

// File: src/stereo_biquad_eq_cascade_unit.sv
// each enabled section runs in turn on each channel; disabled sections are skipped
// the back end finishes one stereo frame before it takes the next queued transaction
// coefficient write and clear are applied in the back end as they are popped in the idle state
// reset: asynchronous active low; coefficients and history read as zero, gain 1.0,
// all sections disabled
// ----------------------------------------------------------------------------
// stereo_biquad_eq_cascade_unit
// stereo six-section biquad equalizer with output gain and saturation
// ----------------------------------------------------------------------------
`default_nettype none
module stereo_biquad_eq_cascade_unit import sbq_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    operation,
	input  wire logic signed [SAMPLE_BITS-1:0] left_in,
	input  wire logic signed [SAMPLE_BITS-1:0] right_in,
	input  wire logic [2:0]                    coef_section,
	input  wire logic [2:0]                    coef_index,
	input  wire logic signed [COEF_BITS-1:0]   coef_value,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0]      left_out,
	output logic signed [SAMPLE_BITS-1:0]      right_out,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [GAIN_BITS-1:0]          cfg_data
);
	logic [SECTIONS-1:0]  enable_q;
	logic [GAIN_BITS-1:0] gain_q;
	item_t                q_item;
	qctl_t                qctl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= '0;
			gain_q   <= GAIN_BITS'(1) << GAIN_FRAC;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_ENABLE) enable_q <= cfg_data[SECTIONS-1:0];
			if (cfg_index == CFG_GAIN) gain_q <= cfg_data;
		end
	end

	sbq_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .operation, .left_in, .right_in,
		.coef_section, .coef_index, .coef_value,
		.q_item, .q_valid(qctl.valid), .q_pop(qctl.pop)
	);

	sbq_back u_back (
		.clk, .arst_n, .q_item, .qin(qctl), .q_pop(qctl.pop),
		.section_enable(enable_q), .output_gain(gain_q),
		.out_valid, .out_stall, .left_out, .right_out
	);
endmodule
`default_nettype wire
